// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
// All of them sample on clk and are held off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every sampled edge.
`define CSA_ASSERT_HOLDS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define CSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/csa_pkg.sv -----
package csa_pkg;

  // field widths
  localparam int GATE_W = 16;   // gate and up values, Q4.11
  localparam int ACT_W  = 18;   // activation, Q6.11
  localparam int CFG_W  = 15;   // register width
  localparam int Z_W    = 31;   // gate times slope, Q.23
  localparam int SIG_W  = 17;   // sigmoid, Q0.16 up to 1.0
  localparam int FRAC_W = 16;   // interpolation fraction

  localparam int SIG_ENTRIES_DEFAULT = 256;

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGMOID_SLOPE = 8'd1;

  localparam logic [CFG_W-1:0] CLAMP_LIMIT_RESET   = 15'd14336;
  localparam logic [CFG_W-1:0] SIGMOID_SLOPE_RESET = 15'd6971;

  // load enables for the three sigmoid stages
  typedef struct packed {
    logic idx_en;
    logic rom_en;
    logic mix_en;
  } csa_sig_en_t;

endpackage

// ----- rtl/core/csa_sigmoid.sv -----
module csa_sigmoid
  import csa_pkg::*;
#(
  parameter int SIGMOID_TABLE_ENTRIES = SIG_ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  csa_sig_en_t             en,
  input  logic signed [Z_W-1:0]   z,
  output logic        [SIG_W-1:0] sig
);

  localparam int N     = SIGMOID_TABLE_ENTRIES;
  localparam int IDX_W = $clog2(N);
  localparam int IWW   = $clog2(N + 1);
  localparam int P_W   = 27 + IWW;
  localparam logic signed [Z_W-1:0] Z_LIM = Z_W'(1 << 26);

  // each ROM word holds a table point and its right neighbour
  typedef logic [N-1:0][2*SIG_W-1:0] rom_t;

  // restoring long division, elaboration only
  function automatic logic [63:0] udiv(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], num[b]};
      if (r >= den) begin
        r = r - den;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid at -8 + 16k/N in Q0.16: Taylor exp(-|x|/16) then squared four times
  function automatic logic [SIG_W-1:0] table_point(logic [63:0] k);
    logic [63:0] n;
    logic [63:0] d;
    logic        neg;
    logic [63:0] a;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] q;
    n = 64'(N);
    if ((k << 1) >= n) begin
      d = (k << 1) - n;
      neg = 1'b0;
    end else begin
      d = n - (k << 1);
      neg = 1'b1;
    end
    a = udiv(d << 30, n << 1);
    term = 64'd1 << 30;
    e = term;
    for (int i = 1; i <= 14; i++) begin
      term = udiv((term * a) >> 30, 64'(i));
      if (i % 2 == 1) e = e - term;
      else            e = e + term;
    end
    for (int j = 0; j < 4; j++)
      e = (e * e + (64'd1 << 29)) >> 30;
    den = (64'd1 << 30) + e;
    if (neg) q = udiv((e << 16) + (den >> 1), den);
    else     q = udiv((64'd1 << 46) + (den >> 1), den);
    return q[SIG_W-1:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        rom;
    logic [SIG_W-1:0] t_prev;
    logic [SIG_W-1:0] t_cur;
    t_prev = table_point(64'd0);
    for (int i = 0; i < N; i++) begin
      t_cur  = table_point(64'(i + 1));
      rom[i] = {t_cur, t_prev};
      t_prev = t_cur;
    end
    return rom;
  endfunction

  localparam rom_t SIG_ROM = build_rom();

  // stage A: range check and table position
  logic signed [Z_W-1:0] zoff;
  logic [P_W-1:0]        pos;
  logic [IWW-1:0]        idx_wide;
  logic [IDX_W-1:0]      idx_next;

  always_comb begin
    zoff     = z + Z_LIM;
    pos      = P_W'(zoff[26:0]) * P_W'(N);
    idx_wide = pos[P_W-1:27];
    if (idx_wide > IWW'(N - 1)) idx_next = IDX_W'(N - 1);
    else                        idx_next = idx_wide[IDX_W-1:0];
  end

  logic [IDX_W-1:0]  idx_a;
  logic [FRAC_W-1:0] frac_a;
  logic              lo_a, hi_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_a <= 1'b0;
      hi_a <= 1'b0;
    end else if (en.idx_en) begin
      lo_a <= (z < -Z_LIM);
      hi_a <= (z >= Z_LIM);
    end
  end

  always_ff @(posedge clk) begin
    if (en.idx_en) begin
      idx_a  <= idx_next;
      frac_a <= pos[26:11];
    end
  end

  // stage B: table read
  logic [2*SIG_W-1:0] pair_b;
  logic [FRAC_W-1:0]  frac_b;
  logic               lo_b, hi_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_b <= 1'b0;
      hi_b <= 1'b0;
    end else if (en.rom_en) begin
      lo_b <= lo_a;
      hi_b <= hi_a;
    end
  end

  always_ff @(posedge clk) begin
    if (en.rom_en) begin
      pair_b <= SIG_ROM[idx_a];
      frac_b <= frac_a;
    end
  end

  // stage C: linear interpolation, t0 + (t1 - t0) * f, rounded
  logic signed [SIG_W:0]      diff;
  logic signed [SIG_W+17:0]   mix;
  logic        [SIG_W-1:0]    sig_next;

  always_comb begin
    diff = signed'({1'b0, pair_b[2*SIG_W-1:SIG_W]}) - signed'({1'b0, pair_b[SIG_W-1:0]});
    mix  = signed'({2'b00, pair_b[SIG_W-1:0], 16'h0000})
         + diff * signed'({1'b0, frac_b})
         + (SIG_W+18)'(32768);
    if (lo_b)      sig_next = '0;
    else if (hi_b) sig_next = SIG_W'(65536);
    else           sig_next = mix[SIG_W+15:16];
  end

  always_ff @(posedge clk) begin
    if (en.mix_en) sig <= sig_next;
  end

endmodule

// ----- rtl/core/clamped_swiglu_activation_unit.sv -----
// Clamped SwiGLU activation: one (gate, up) pair in, one Q6.11 result out.
// Eight register stages (clamp, gate*slope, table position, table read,
// interpolation, gate*sigmoid, (up+1)*glu, round and saturate); a new pair
// is taken every cycle while the output is not stalled. Each stage holds
// its word only while the stage after it is full, so a stalled output
// still lets input words in until the pipe is full.
// The sigmoid table is a constant ROM of SIGMOID_TABLE_ENTRIES point pairs
// built at elaboration; there is no clearing pass after reset. Registers
// are written through the cfg channel, which is always ready.
`include "assert_macros.svh"

module clamped_swiglu_activation_unit
  import csa_pkg::*;
#(
  parameter int SIGMOID_TABLE_ENTRIES = SIG_ENTRIES_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  // stream in
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,   // [15:0] gate_value, [31:16] up_value
  // stream out
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [17:0] activation, [23:18] zero
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int STAGES = 8;
  localparam int PROD_W = 17 + 32;

  // configuration registers
  logic [CFG_W-1:0] clamp_limit;
  logic [CFG_W-1:0] sigmoid_slope;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_limit   <= CLAMP_LIMIT_RESET;
      sigmoid_slope <= SIGMOID_SLOPE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CLAMP_LIMIT:   clamp_limit   <= cfg_data[CFG_W-1:0];
        CFG_SIGMOID_SLOPE: sigmoid_slope <= cfg_data[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control: a stage loads when empty or when the next one loads
  logic [STAGES:1] vld;
  logic [STAGES:1] adv;

  always_comb begin
    adv[STAGES] = !vld[STAGES] || m_tready;
    for (int k = STAGES - 1; k >= 1; k--)
      adv[k] = !vld[k] || adv[k+1];
  end

  assign s_tready = adv[1];
  assign m_tvalid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[1]) vld[1] <= s_tvalid;
      for (int k = 2; k <= STAGES; k++)
        if (adv[k]) vld[k] <= vld[k-1];
    end
  end

  // stage 1: clamp gate from above, up to +/- limit
  logic signed [GATE_W-1:0] g_in, u_in, lim, gc_next, uc_next;

  always_comb begin
    g_in = signed'(s_tdata[15:0]);
    u_in = signed'(s_tdata[31:16]);
    lim  = signed'({1'b0, clamp_limit});
    gc_next = (g_in > lim) ? lim : g_in;
    if (u_in > lim)       uc_next = lim;
    else if (u_in < -lim) uc_next = -lim;
    else                  uc_next = u_in;
  end

  // gate and up travel alongside the sigmoid stages
  logic signed [GATE_W-1:0] gc_pipe [1:5];
  logic signed [GATE_W-1:0] uc_pipe [1:5];

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      gc_pipe[1] <= gc_next;
      uc_pipe[1] <= uc_next;
    end
    for (int k = 2; k <= 5; k++) begin
      if (adv[k]) begin
        gc_pipe[k] <= gc_pipe[k-1];
        uc_pipe[k] <= uc_pipe[k-1];
      end
    end
  end

  // stage 2: z = gate * slope, Q.23
  logic signed [31:0]    z_full;
  logic signed [Z_W-1:0] z;

  assign z_full = gc_pipe[1] * signed'({1'b0, sigmoid_slope});

  always_ff @(posedge clk) begin
    if (adv[2]) z <= z_full[Z_W-1:0];
  end

  // stages 3 to 5: sigmoid lookup
  csa_sig_en_t      sig_en;
  logic [SIG_W-1:0] sig;

  assign sig_en = '{idx_en: adv[3], rom_en: adv[4], mix_en: adv[5]};

  csa_sigmoid #(
    .SIGMOID_TABLE_ENTRIES(SIGMOID_TABLE_ENTRIES)
  ) u_sigmoid (
    .clk (clk),
    .rst (rst),
    .en  (sig_en),
    .z   (z),
    .sig (sig)
  );

  // stage 6: glu = gate * sigmoid, up + 1
  logic signed [31:0] glu;
  logic signed [16:0] up1;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      glu <= 32'(gc_pipe[5] * signed'({1'b0, sig}));
      up1 <= 17'(uc_pipe[5]) + 17'sd2048;
    end
  end

  // stage 7: full product, Q.38
  logic signed [PROD_W-1:0] prod;

  always_ff @(posedge clk) begin
    if (adv[7]) prod <= up1 * glu;
  end

  // stage 8: round half up to Q.11 and saturate
  logic signed [PROD_W:0]    prod_rnd;
  logic signed [PROD_W-27:0] r_wide;
  logic signed [ACT_W-1:0]   act_next;
  logic        [ACT_W-1:0]   act;

  always_comb begin
    prod_rnd = (PROD_W+1)'(prod) + (PROD_W+1)'(1 << 26);
    r_wide   = prod_rnd[PROD_W:27];
    if (r_wide > (PROD_W-26)'(131071))       act_next = 18'sd131071;
    else if (r_wide < -(PROD_W-26)'(131072)) act_next = -18'sd131072;
    else                                     act_next = r_wide[ACT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv[STAGES]) act <= act_next;
  end

  assign m_tdata = {6'b000000, act};

  // checks
  `CSA_ASSERT_IMPL(a_stall_means_full, !s_tready, &vld, "input stalled with a bubble in the pipe")
  `CSA_ASSERT_IMPL(a_empty_out_takes, !m_tvalid, s_tready, "input stalled with an empty output stage")
  `CSA_ASSERT_NEXT(a_clamp_held, vld[1] && !adv[1], vld[1] && $stable(gc_pipe[1]), "stage one lost its word")

endmodule
